FILE: rtl/secure_token_record_deframer_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the token record deframer
// Simulation-only concurrent checks; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef SECURE_TOKEN_RECORD_DEFRAMER_CORE_MACROS_SVH
`define SECURE_TOKEN_RECORD_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define STRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define STRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STRD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define STRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/strd_pkg.sv
// ---------------------------------------------------------------------------
// Token record deframer package
// Constants, phase type and helper functions for the deframer core.
// ---------------------------------------------------------------------------
package strd_pkg;

    // widest body length accepted (16 to 32)
    localparam int LENGTH_BITS = 32;

    localparam logic [7:0] TLS_LO     = 8'd20;
    localparam logic [7:0] TLS_HI     = 8'd23;
    localparam logic [7:0] VENDOR_TAG = 8'd26;
    localparam logic [7:0] SSL2_BIT   = 8'h80;
    localparam logic [7:0] SSL2_MASK  = 8'h7f;

    localparam logic [1:0] MODE_PREFIX = 2'd0;
    localparam logic [1:0] MODE_TLS    = 2'd1;
    localparam logic [1:0] MODE_SSL2   = 2'd2;
    localparam logic [1:0] MODE_VENDOR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLEAN = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // header byte counts at which each format's header is complete
    localparam logic [2:0] PREFIX_HDR = 3'd4;
    localparam logic [2:0] SSL2_HDR   = 3'd4;
    localparam logic [2:0] TLS_HDR    = 3'd5;

    localparam logic [14:0] SSL2_MIN   = 15'd2;
    localparam logic [15:0] VENDOR_MIN = 16'd4;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_HASH   = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    function automatic logic [1:0] pick_mode(input logic [7:0] b);
        logic [1:0] m;
        if (b >= TLS_LO && b <= TLS_HI)
            m = MODE_TLS;
        else if (b == VENDOR_TAG)
            m = MODE_VENDOR;
        else if ((b & SSL2_BIT) != 8'd0)
            m = MODE_SSL2;
        else
            m = MODE_PREFIX;
        return m;
    endfunction

    function automatic logic too_long(input logic [31:0] len);
        return (len >> LENGTH_BITS) != 32'd0;
    endfunction

endpackage

FILE: rtl/secure_token_record_deframer_core.sv
// ---------------------------------------------------------------------------
// Token record deframer core
// Delimits TLS, SSL2, vendor SSL and length-prefixed token records.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one stream byte per word in s_tdata. s_tuser set
//   means the connection closed; that word carries no byte and its result
//   reports a clean end (status 1) or truncation / latched error (status 2),
//   then all framing state returns to its reset value.
//   Output channel m_*: one word per input word. m_tdata echoes the byte,
//   m_tlast marks the byte that completes a record, m_tuser carries
//   in_token, frame_mode and status.
//   The output is registered: output valid follows input accept in the next
//   cycle; throughput is one word per cycle while the receiver keeps up,
//   set by the single result register, which is refilled in the same cycle it is taken.
//   When the receiver stalls, the result register holds and s_tready drops
//   until the pending word is taken.
//   Reset (rst_n low) empties the result register and puts the framer in
//   idle with no error latched.
// ---------------------------------------------------------------------------
`include "secure_token_record_deframer_core_macros.svh"

module secure_token_record_deframer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] stream_done
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // record_end
    output logic [4:0] m_tuser    // [0] in_token, [2:1] frame_mode, [4:3] status
);

    localparam int LB = strd_pkg::LENGTH_BITS;

    strd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]    mode_reg, mode_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [31:0]   hdr_reg, hdr_next;
    logic [LB-1:0] body_reg, body_next;
    logic [15:0]   hash_reg, hash_next;
    logic [31:0]   tail_reg, tail_next;
    logic          err_reg, err_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_tok_reg, out_end_reg;
    logic [1:0]    out_mode_reg, out_st_reg;

    logic          accept;
    logic [7:0]    o_byte;
    logic          o_tok, o_end;
    logic [1:0]    o_mode, o_st;
    logic          bad, start_body;
    logic [31:0]   body_len;
    logic [14:0]   ssl2_len;
    logic [15:0]   short_len;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        body_next  = body_reg;
        hash_next  = hash_reg;
        tail_next  = tail_reg;
        err_next   = err_reg;
        o_byte     = s_tdata;
        o_tok      = 1'b0;
        o_end      = 1'b0;
        o_st       = strd_pkg::ST_OK;
        o_mode     = mode_reg;
        bad        = 1'b0;
        start_body = 1'b0;
        body_len   = 32'd0;
        ssl2_len   = 15'd0;
        short_len  = 16'd0;

        if (s_tuser) begin
            // connection closed: report and drop all framing state
            o_byte = 8'd0;
            o_st   = (phase_reg == strd_pkg::PH_IDLE && !err_reg) ?
                     strd_pkg::ST_CLEAN : strd_pkg::ST_ERR;
            phase_next = strd_pkg::PH_IDLE;
            mode_next  = strd_pkg::MODE_PREFIX;
            cnt_next   = 3'd0;
            hdr_next   = 32'd0;
            body_next  = '0;
            hash_next  = 16'd0;
            tail_next  = 32'd0;
            err_next   = 1'b0;
        end else if (err_reg) begin
            o_st = strd_pkg::ST_ERR;
        end else begin
            case (phase_reg)
                strd_pkg::PH_HEADER:
                begin
                    hdr_next  = {hdr_reg[23:0], s_tdata};
                    cnt_next  = cnt_reg + 3'd1;
                    o_tok     = (mode_reg != strd_pkg::MODE_PREFIX);
                    ssl2_len  = {hdr_next[30:24], hdr_next[23:16]};
                    short_len = {hdr_reg[7:0], s_tdata};
                    if (mode_reg == strd_pkg::MODE_PREFIX && cnt_next >= strd_pkg::PREFIX_HDR)
                    begin
                        if (strd_pkg::too_long(hdr_next))
                            bad = 1'b1;
                        else begin
                            start_body = 1'b1;
                            body_len   = hdr_next;
                        end
                    end else if (mode_reg == strd_pkg::MODE_SSL2 &&
                                 cnt_next >= strd_pkg::SSL2_HDR)
                    begin
                        if (ssl2_len < strd_pkg::SSL2_MIN)
                            bad = 1'b1;
                        else begin
                            start_body = 1'b1;
                            body_len   = {17'd0, ssl2_len - strd_pkg::SSL2_MIN};
                        end
                    end else if (mode_reg == strd_pkg::MODE_TLS &&
                                 cnt_next >= strd_pkg::TLS_HDR)
                    begin
                        start_body = 1'b1;
                        body_len   = {16'd0, short_len};
                    end else if (mode_reg == strd_pkg::MODE_VENDOR &&
                                 cnt_next >= strd_pkg::TLS_HDR)
                    begin
                        if (short_len < strd_pkg::VENDOR_MIN)
                            bad = 1'b1;
                        else begin
                            hash_next  = short_len;
                            tail_next  = 32'd0;
                            phase_next = strd_pkg::PH_HASH;
                        end
                    end
                end
                strd_pkg::PH_HASH:
                begin
                    o_tok     = 1'b1;
                    tail_next = {tail_reg[23:0], s_tdata};
                    hash_next = hash_reg - 16'd1;
                    // last four hash bytes carry the body length
                    if (hash_next == 16'd0) begin
                        if (strd_pkg::too_long(tail_next))
                            bad = 1'b1;
                        else begin
                            start_body = 1'b1;
                            body_len   = tail_next;
                        end
                    end
                end
                strd_pkg::PH_BODY:
                begin
                    o_tok     = 1'b1;
                    body_next = body_reg - LB'(1);
                    if (body_next == '0) begin
                        o_end      = 1'b1;
                        phase_next = strd_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    mode_next  = strd_pkg::pick_mode(s_tdata);
                    hdr_next   = {24'd0, s_tdata};
                    cnt_next   = 3'd1;
                    phase_next = strd_pkg::PH_HEADER;
                    o_tok      = (mode_next != strd_pkg::MODE_PREFIX);
                end
            endcase

            if (start_body) begin
                // empty body ends the record on this byte
                if (body_len == 32'd0) begin
                    o_end      = 1'b1;
                    phase_next = strd_pkg::PH_IDLE;
                end else begin
                    body_next  = body_len[LB-1:0];
                    phase_next = strd_pkg::PH_BODY;
                end
            end

            if (bad) begin
                err_next   = 1'b1;
                phase_next = strd_pkg::PH_IDLE;
                o_tok      = 1'b0;
                o_end      = 1'b0;
                o_st       = strd_pkg::ST_BAD;
            end
            o_mode = mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= strd_pkg::PH_IDLE;
            mode_reg      <= strd_pkg::MODE_PREFIX;
            cnt_reg       <= 3'd0;
            hdr_reg       <= 32'd0;
            body_reg      <= '0;
            hash_reg      <= 16'd0;
            tail_reg      <= 32'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                hdr_reg   <= hdr_next;
                body_reg  <= body_next;
                hash_reg  <= hash_next;
                tail_reg  <= tail_next;
                err_reg   <= err_next;
            end
            if (s_tready)
                out_valid_reg <= s_tvalid;
        end
    end

    // result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_byte_reg <= o_byte;
            out_tok_reg  <= o_tok;
            out_end_reg  <= o_end;
            out_mode_reg <= o_mode;
            out_st_reg   <= o_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = {out_st_reg, out_mode_reg, out_tok_reg};

    `STRD_ASSERT_NEXT(a_done_clears, clk, rst_n, accept && s_tuser,
        phase_reg == strd_pkg::PH_IDLE && !err_reg)
    `STRD_ASSERT_NEXT(a_err_reports, clk, rst_n, accept && !s_tuser && err_reg,
        out_st_reg == strd_pkg::ST_ERR && err_reg)
    `STRD_ASSERT_NOW(a_body_nonzero, clk, rst_n, phase_reg == strd_pkg::PH_BODY,
        body_reg != '0)
    `STRD_ASSERT_NOW(a_bad_latches, clk, rst_n,
        m_tvalid && out_st_reg == strd_pkg::ST_BAD && !s_tvalid,
        err_reg && !out_tok_reg && !out_end_reg)

endmodule
